// ===== rtl/swmf_pkg.sv =====
// Shared constants and types for the sliding window mean filter.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package swmf_pkg;

  // Number of samples the window holds.
  localparam int WINDOW_LENGTH = 50;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int CNT_W    = $clog2(WINDOW_LENGTH + 1);
  // The sum of WINDOW_LENGTH samples of SAMPLE_W bits never overflows this width.
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_LENGTH);
  localparam int STEP_W   = $clog2(SUM_W + 1);

  localparam logic [CNT_W-1:0]  WIN_CNT  = CNT_W'(WINDOW_LENGTH);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(WINDOW_LENGTH - 1);
  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(SUM_W);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // Status of the iterative divider as seen by the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } swmf_div_sts_t;

endpackage

`default_nettype wire

// ===== rtl/swmf_ring_ram.sv =====
// Ring store of the last WINDOW_LENGTH samples: one write port, one read port,
// read data registered. Depends on swmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swmf_ring_ram (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [swmf_pkg::IDX_W-1:0] waddr_i,
  input  wire swmf_pkg::sample_t    wdata_i,
  input  wire                       re_i,
  input  wire [swmf_pkg::IDX_W-1:0] raddr_i,
  output swmf_pkg::sample_t         rdata_o
);
  import swmf_pkg::*;

  sample_t mem [WINDOW_LENGTH];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/swmf_divider.sv =====
// Restoring divider, one quotient bit per cycle, signed dividend and
// unsigned count divisor, quotient truncated toward zero. Depends on swmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swmf_divider (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire swmf_pkg::sum_t       dividend_i,
  input  wire [swmf_pkg::CNT_W-1:0] divisor_i,
  input  wire                       ack_i,
  output swmf_pkg::swmf_div_sts_t   sts_o,
  output swmf_pkg::sample_t         quotient_o
);
  import swmf_pkg::*;

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic              neg_q, neg_d;

  logic [CNT_W:0]    rem_shift;
  logic              fits;

  always_comb begin
    rem_shift = {rem_q, quo_q[SUM_W-1]};
    fits      = (rem_shift >= {1'b0, dvs_q});

    run_d  = run_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;

    if (ack_i) begin
      done_d = 1'b0;
    end

    if (start_i) begin
      // Work on the magnitude; the sign is put back at the end.
      run_d = 1'b1;
      cnt_d = DIV_STEPS;
      rem_d = '0;
      quo_d = dividend_i[SUM_W-1] ? (SUM_W'(0) - dividend_i) : dividend_i;
      dvs_d = divisor_i;
      neg_d = dividend_i[SUM_W-1];
    end else if (run_q) begin
      rem_d = fits ? CNT_W'(rem_shift - {1'b0, dvs_q}) : rem_shift[CNT_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], fits};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign sts_o.busy = run_q;
  assign sts_o.done = done_q;
  assign quotient_o = neg_q ? (SAMPLE_W'(0) - quo_q[SAMPLE_W-1:0]) : quo_q[SAMPLE_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/sliding_window_mean_filter_top.sv =====
// Sliding window mean filter: the mean of the last WINDOW_LENGTH samples.
// The mean word passes through ST_UPD, the divider and the output register once its sample word is accepted.
// No new sample word is accepted until the last one's mean word is loaded; the 22-step divider sets this pace.
// Reset clears the sum, fill count, write index and handshake state; the sample
// store itself is not cleared, since an entry is read only after it was written.
// Depends on swmf_pkg, swmf_ring_ram and swmf_divider.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_mean_filter_top (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire swmf_pkg::sample_t  sample_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output swmf_pkg::sample_t       mean_o
);
  import swmf_pkg::*;

  // Controller states.
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a sample word
  localparam logic [1:0] ST_UPD  = 2'd1;  // old sample read back, update sum
  localparam logic [1:0] ST_DIV  = 2'd2;  // divider running or result waiting

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] widx_q, widx_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  sum_t             sum_q, sum_d;
  sample_t          smp_q;
  logic             out_valid_q, out_valid_d;
  sample_t          mean_q, mean_d;

  logic             in_accept;
  logic             full;
  sample_t          old_smp;
  logic             div_start;
  logic             div_ack;
  swmf_div_sts_t    div_sts;
  sample_t          div_quo;
  logic             out_free;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign full      = (fill_q == WIN_CNT);
  assign out_free  = !out_valid_q || !out_stall_i;

  // The sample store is read at the write index when a word is accepted; the
  // old sample comes back in ST_UPD, when the same entry is overwritten. Only
  // one word is in flight, so a read and a write of one entry never overlap.
  swmf_ring_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_UPD),
    .waddr_i (widx_q),
    .wdata_i (smp_q),
    .re_i    (in_accept),
    .raddr_i (widx_q),
    .rdata_o (old_smp)
  );

  swmf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (fill_d),
    .ack_i      (div_ack),
    .sts_o      (div_sts),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    widx_d      = widx_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    mean_d      = mean_q;
    div_start   = 1'b0;
    div_ack     = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        // While filling, the sample is added and counted; once full, the
        // oldest sample in the slot being overwritten leaves the sum.
        if (full) begin
          sum_d = sum_q + SUM_W'(smp_q) - SUM_W'(old_smp);
        end else begin
          sum_d  = sum_q + SUM_W'(smp_q);
          fill_d = fill_q + CNT_W'(1);
        end
        widx_d    = (widx_q == IDX_LAST) ? '0 : widx_q + IDX_W'(1);
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        // The quotient waits in the divider until the output register is free.
        if (div_sts.done && out_free) begin
          div_ack     = 1'b1;
          mean_d      = div_quo;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      widx_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      widx_q      <= widx_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      smp_q <= sample_i;
    end
    mean_q <= mean_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_q;

  // The fill count never passes the window length.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= WIN_CNT)
    else $error("fill count beyond window length");

  // The write index stays inside the store.
  a_widx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    widx_q <= IDX_LAST)
    else $error("write index outside store");

  // While the window fills, slots are written in order from the first one.
  a_fill_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> (CNT_W'(widx_q) == fill_q))
    else $error("write index out of step with fill count");

  // The divider is started only when it is idle.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (!div_sts.busy && !div_sts.done))
    else $error("divider started while busy");

  // A new mean word is loaded only from a finished division.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !(out_valid_q && out_stall_i)) |-> (state_q == ST_DIV && div_sts.done))
    else $error("mean word loaded without a finished division");

endmodule

`default_nettype wire

// ===== verif/swmf_mean_checker.sv =====
// Scoreboard for the sliding window mean filter: predicts each mean word and compares it.
// Depends on swmf_pkg for the sample type and the window length.
`timescale 1ns / 1ps

module swmf_mean_checker (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire                in_stall_i,
  input  swmf_pkg::sample_t  sample_i,
  input  wire                out_valid_i,
  input  wire                out_stall_i,
  input  swmf_pkg::sample_t  mean_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import swmf_pkg::*;

  // Shadow copy of the filter state.
  sample_t     window_q [WINDOW_LENGTH];
  int unsigned slot_q;
  int unsigned held_q;
  longint      window_sum_q;
  sample_t     mean_queue [$];
  int          errors_q;

  assign fail_count_o = errors_q;

  // Adds one sample to the window and returns the new mean, truncated toward zero.
  function automatic sample_t add_sample_mean(input sample_t s);
    longint avg;
    if (held_q < WINDOW_LENGTH) begin
      window_sum_q += longint'(s);
      held_q++;
    end else begin
      window_sum_q += longint'(s) - longint'(window_q[slot_q]);
    end
    window_q[slot_q] = s;
    slot_q = (slot_q == WINDOW_LENGTH - 1) ? 0 : slot_q + 1;
    avg = window_sum_q / longint'(held_q);
    return sample_t'(avg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want;
    if (!rst_ni) begin
      slot_q = 0;
      held_q = 0;
      window_sum_q = 0;
      mean_queue.delete();
      errors_q <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (mean_queue.size() == 0) begin
          $error("mean: expected none, got %0d", mean_i);
          errors_q <= errors_q + 1;
        end else begin
          want = mean_queue.pop_front();
          if (mean_i !== want) begin
            $error("mean: expected %0d, got %0d", want, mean_i);
            errors_q <= errors_q + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        mean_queue.push_back(add_sample_mean(sample_i));
      end
      pending_o <= mean_queue.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the sliding window mean filter testbench: clock, reset, stimulus and verdict.
// Depends on swmf_pkg, sliding_window_mean_filter_top and swmf_mean_checker.
`timescale 1ns / 1ps

module tb_top;
  import swmf_pkg::*;

  // Kinds of sample bursts in the random part. Runs of one extreme value at least as
  // long as the window push the mean to the ends of its range once the window is full,
  // and small values around zero show whether negative means truncate toward zero.
  typedef enum int {
    BURST_RANDOM,
    BURST_MAX,
    BURST_MIN,
    BURST_SMALL,
    BURST_ALTERNATE
  } burst_e;

  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  // Number of random sample words to send after the directed part.
  localparam int RANDOM_WORDS = 1000;
  // The receiver refuses mean words for this long once, so the block backs up.
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD_CYCLES = 400;
  // Time to watch for stray mean words after the last one is out.
  localparam int TAIL_CYCLES = 40;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  sample_t sample;
  logic    out_valid;
  logic    out_stall;
  sample_t mean;
  int      fail_count;
  int      pending;

  always #5 clk = ~clk;

  sliding_window_mean_filter_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .mean_o      (mean)
  );

  // The checker sees both channels exactly as the block does and keeps its own
  // copy of the window, so the top only has to make stimulus.
  swmf_mean_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .sample_i     (sample),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .mean_i       (mean),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offers one sample word after a random gap (none when quiet) and returns at the edge where it is taken.
  // With no gap, valid simply stays high and the next word follows straight away.
  task automatic send_word(input sample_t s, input bit quiet);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops sending until every mean word the checker waits for has come out.
  // The first edge lets the checker's count catch up with the last accepted word.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: after each accepted mean word it draws a stall of random length.
  // Every fourth stretch of 64 words goes without stalls, and at one point the
  // receiver holds off for a long time while the sender keeps offering words.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned taken;
    hold_left = 0;
    taken = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        taken++;
        if (taken == LONG_HOLD_AT) begin
          hold_left = LONG_HOLD_CYCLES;
        end else if ((taken / 64) % 4 == 3) begin
          hold_left = 0;
        end else begin
          hold_left = $urandom_range(0, 4);
        end
      end
      out_stall <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
    end
  end

  initial begin : stimulus
    sample_t     directed_set [$];
    sample_t     s;
    burst_e      kind;
    bit          quiet;
    int unsigned burst_len;
    int unsigned sent;

    rst_n = 1'b0;
    in_valid = 1'b0;
    sample = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: both ends of the sample range while the window fills, so the
    // mean is taken over a growing count, plus odd sums of either sign that must
    // truncate toward zero and patterns that toggle every bit of the sample.
    directed_set = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'shffff, 16'sh0001, 16'shfffe,
                     16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh5555, 16'shaaaa,
                     16'sh0003, 16'shfffd, 16'shfff9, 16'sh0007, 16'sh00ff, 16'shff00,
                     16'sh0100, 16'sheffe, 16'sh8001, 16'sh7ffe};
    foreach (directed_set[k]) send_word(directed_set[k], 1'b0);
    wait_drained();

    // Random part: bursts of one kind each. Bursts of extremes are at least as long as the
    // window, so the full window and the wrap of the write index are reached often.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      kind = burst_e'($urandom_range(0, 4));
      quiet = ($urandom_range(0, 3) == 0);
      if (kind == BURST_MAX || kind == BURST_MIN) begin
        burst_len = $urandom_range(50, 60);
      end else begin
        burst_len = $urandom_range(20, 80);
      end
      for (int k = 0; k < burst_len; k++) begin
        case (kind)
          BURST_MAX: begin
            s = SAMPLE_MAX;
          end
          BURST_MIN: begin
            s = SAMPLE_MIN;
          end
          BURST_SMALL: begin
            s = sample_t'(int'($urandom_range(0, 16)) - 8);
          end
          BURST_ALTERNATE: begin
            s = (k % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
          end
          default: begin
            s = sample_t'($urandom);
          end
        endcase
        send_word(s, quiet);
      end
      sent += burst_len;
      // Now and then the sender goes quiet until every mean word is out.
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    // Let the last mean words out, then watch a while longer for stray ones.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // A correct run takes well under half a millisecond, so this only fires on a hang.
  initial begin : watchdog
    #3_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
